FILE: rtl/smma_pkg.sv
// Shared constants and types for the small matrix multiply-add unit.
package smma_pkg;

  // Matrix size and derived counts
  localparam int DIM   = 3;
  localparam int CELLS = DIM * DIM;
  localparam int KW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int IDX_W = $clog2(CELLS);

  // Field widths
  localparam int DATA_W      = 16;
  localparam int VALUE_W     = 35;
  localparam int RC_W        = 3;
  localparam int IN_TDATA_W  = 2 * DATA_W;
  localparam int OUT_FIELD_W = VALUE_W + 2 * RC_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int PAD_W       = OUT_TDATA_W - OUT_FIELD_W;
  localparam int FRAC_W      = 8;

  // Operation modes
  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_MUL = 1'b1;

  // Element of A travelling along the cell row
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] a;
    logic [KW-1:0]            k;
    logic [KW-1:0]            row;
  } tok_t;

  // Finished result element from one cell
  typedef struct packed {
    logic                      done;
    logic signed [VALUE_W-1:0] value;
    logic [KW-1:0]             row;
  } res_t;

endpackage

FILE: rtl/small_matrix_multiply_add_unit.sv
// Top level: load sequencer, row of column cells and output register.
// Operation: DIM*DIM load transfers, then one result per cycle while the output
//   is ready; input is held off from the last pair until the last result transfers.
// Reset clears the counters, state and valid flags; operation_mode resets to 1.
module small_matrix_multiply_add_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write: bit 0 = operation_mode
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_data_i,
  // tdata: a_value[15:0], b_value[31:16]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [smma_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tdata: result_value[34:0], result_row[37:35], result_col[40:38], zero pad
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [smma_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_FEED  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]                         state_q, state_d;
  logic                               op_mode_q, run_mode_q;
  logic [smma_pkg::IDX_W-1:0]         ld_idx_q, feed_idx_q;
  logic [smma_pkg::KW-1:0]            ld_row_q, ld_col_q, feed_row_q, feed_k_q;
  logic signed [smma_pkg::DATA_W-1:0] a_store_q [smma_pkg::CELLS];
  logic                               in_xfer, out_xfer, adv, last_pair, last_feed;
  logic signed [smma_pkg::DATA_W-1:0] in_a, in_b;
  smma_pkg::tok_t                     tok_w [smma_pkg::DIM+1];
  smma_pkg::res_t                     res_w [smma_pkg::DIM];
  logic [smma_pkg::DIM-1:0]           done_vec;
  logic                               any_done;
  logic signed [smma_pkg::VALUE_W-1:0] sel_value;
  logic [smma_pkg::KW-1:0]            sel_row, sel_col;
  logic                               out_valid_q, out_last_q;
  logic signed [smma_pkg::VALUE_W-1:0] out_value_q;
  logic [smma_pkg::KW-1:0]            out_row_q, out_col_q;

  assign in_a      = s_axis_tdata[smma_pkg::DATA_W-1:0];
  assign in_b      = s_axis_tdata[smma_pkg::IN_TDATA_W-1:smma_pkg::DATA_W];
  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_xfer  = m_axis_tvalid && m_axis_tready;
  assign adv       = !out_valid_q || m_axis_tready;
  assign last_pair = (ld_idx_q == smma_pkg::IDX_W'(smma_pkg::CELLS - 1));
  assign last_feed = (feed_idx_q == smma_pkg::IDX_W'(smma_pkg::CELLS - 1));

  // Configuration register, always ready
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q <= smma_pkg::MODE_MUL;
    end else if (cfg_valid_i) begin
      op_mode_q <= cfg_data_i;
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer && last_pair) state_d = ST_FEED;
      end
      ST_FEED: begin
        if (adv && last_feed) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_xfer && out_last_q) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Load and feed counters, mode sampled on the last pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      run_mode_q <= smma_pkg::MODE_MUL;
      ld_idx_q   <= '0;
      ld_row_q   <= '0;
      ld_col_q   <= '0;
      feed_idx_q <= '0;
      feed_row_q <= '0;
      feed_k_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        if (last_pair) begin
          ld_idx_q   <= '0;
          ld_row_q   <= '0;
          ld_col_q   <= '0;
          run_mode_q <= op_mode_q;
        end else begin
          ld_idx_q <= ld_idx_q + 1'b1;
          if (ld_col_q == smma_pkg::KW'(smma_pkg::DIM - 1)) begin
            ld_col_q <= '0;
            ld_row_q <= ld_row_q + 1'b1;
          end else begin
            ld_col_q <= ld_col_q + 1'b1;
          end
        end
      end
      if ((state_q == ST_FEED) && adv) begin
        if (last_feed) begin
          feed_idx_q <= '0;
          feed_row_q <= '0;
          feed_k_q   <= '0;
        end else begin
          feed_idx_q <= feed_idx_q + 1'b1;
          if (feed_k_q == smma_pkg::KW'(smma_pkg::DIM - 1)) begin
            feed_k_q   <= '0;
            feed_row_q <= feed_row_q + 1'b1;
          end else begin
            feed_k_q <= feed_k_q + 1'b1;
          end
        end
      end
    end
  end

  // Hold the elements of A until they are fed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_store_q[ld_idx_q] <= in_a;
    end
  end

  // Feed A row by row into the first cell
  assign tok_w[0].valid = (state_q == ST_FEED);
  assign tok_w[0].a     = a_store_q[feed_idx_q];
  assign tok_w[0].k     = feed_k_q;
  assign tok_w[0].row   = feed_row_q;

  // Row of column cells
  for (genvar j = 0; j < smma_pkg::DIM; j++) begin : g_cell
    smma_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .mode_i   (run_mode_q),
      .col_i    (smma_pkg::KW'(j)),
      .wr_en_i  (in_xfer),
      .wr_row_i (ld_row_q),
      .wr_col_i (ld_col_q),
      .wr_b_i   (in_b),
      .tok_i    (tok_w[j]),
      .tok_o    (tok_w[j+1]),
      .res_o    (res_w[j])
    );
    assign done_vec[j] = res_w[j].done;
  end

  // Select the one cell that finished this cycle
  always_comb begin
    sel_value = '0;
    sel_row   = '0;
    sel_col   = '0;
    for (int j = 0; j < smma_pkg::DIM; j++) begin
      if (done_vec[j]) begin
        sel_value = sel_value | res_w[j].value;
        sel_row   = sel_row | res_w[j].row;
        sel_col   = sel_col | smma_pkg::KW'(j);
      end
    end
  end
  assign any_done = |done_vec;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= any_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_value_q <= sel_value;
      out_row_q   <= sel_row;
      out_col_q   <= sel_col;
      out_last_q  <= (sel_row == smma_pkg::KW'(smma_pkg::DIM - 1))
                  && (sel_col == smma_pkg::KW'(smma_pkg::DIM - 1));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{smma_pkg::PAD_W{1'b0}},
                          smma_pkg::RC_W'(out_col_q),
                          smma_pkg::RC_W'(out_row_q),
                          out_value_q};

  // At most one cell completes an element per cycle
  a_one_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(done_vec))
    else $error("several cells finished in the same cycle");

  // No result is pending while loading
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> !m_axis_tvalid)
    else $error("result pending while loading");

  // The last flag only rides on the corner element
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (out_row_q == smma_pkg::KW'(smma_pkg::DIM - 1))
      && (out_col_q == smma_pkg::KW'(smma_pkg::DIM - 1)))
    else $error("last flag on a non-corner element");

  // Feeding starts with both counters back at zero
  a_feed_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_FEED) |-> (ld_idx_q == '0) && (feed_idx_q == '0))
    else $error("feed started with counters out of step");

endmodule

FILE: rtl/smma_cell.sv
// One column cell: holds a column of B and produces one result column, accumulating products in multiply mode.
module smma_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic                             mode_i,
  input  logic [smma_pkg::KW-1:0]          col_i,
  input  logic                             wr_en_i,
  input  logic [smma_pkg::KW-1:0]          wr_row_i,
  input  logic [smma_pkg::KW-1:0]          wr_col_i,
  input  logic signed [smma_pkg::DATA_W-1:0] wr_b_i,
  input  smma_pkg::tok_t                   tok_i,
  output smma_pkg::tok_t                   tok_o,
  output smma_pkg::res_t                   res_o
);

  logic signed [smma_pkg::DATA_W-1:0]   bcol_q [smma_pkg::DIM];
  logic signed [smma_pkg::VALUE_W-1:0]  acc_q, acc_d;
  logic signed [smma_pkg::DATA_W-1:0]   b_sel;
  logic signed [2*smma_pkg::DATA_W-1:0] prod;
  logic signed [smma_pkg::VALUE_W-1:0]  mac, sum;
  logic [smma_pkg::KW-1:0]              b_idx;
  logic                                 tok_valid_q, res_done_q;
  logic signed [smma_pkg::DATA_W-1:0]   tok_a_q;
  logic [smma_pkg::KW-1:0]              tok_k_q, tok_row_q, res_row_q;
  logic signed [smma_pkg::VALUE_W-1:0]  res_value_q;

  // Store this cell's column of B while loading
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_col_i == col_i)) begin
      bcol_q[wr_row_i] <= wr_b_i;
    end
  end

  // Pick the B entry: row k for the product, the token's row for the sum
  assign b_idx = (mode_i == smma_pkg::MODE_MUL) ? tok_i.k : tok_i.row;
  assign b_sel = bcol_q[b_idx];
  assign prod  = tok_i.a * b_sel;
  assign mac   = ((tok_i.k == '0) ? '0 : acc_q) + smma_pkg::VALUE_W'(prod);
  assign sum   = (smma_pkg::VALUE_W'(tok_i.a) <<< smma_pkg::FRAC_W)
               + smma_pkg::VALUE_W'(b_sel);

  always_comb begin
    acc_d = acc_q;
    if (mode_i == smma_pkg::MODE_MUL) begin
      acc_d = mac;
    end else if (tok_i.k == col_i) begin
      acc_d = sum;
    end
  end

  // Control: pass the token on, flag completion on the last k
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
      res_done_q  <= 1'b0;
    end else if (adv_i) begin
      tok_valid_q <= tok_i.valid;
      res_done_q  <= tok_i.valid && (tok_i.k == smma_pkg::KW'(smma_pkg::DIM - 1));
    end
  end

  // Payload: accumulator, forwarded token and result
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_a_q   <= tok_i.a;
      tok_k_q   <= tok_i.k;
      tok_row_q <= tok_i.row;
      if (tok_i.valid) begin
        acc_q       <= acc_d;
        res_value_q <= acc_d;
        res_row_q   <= tok_i.row;
      end
    end
  end

  // Pack in member order, first member in the top bits
  assign tok_o = {tok_valid_q, tok_a_q, tok_k_q, tok_row_q};
  assign res_o = {res_done_q, res_value_q, res_row_q};

endmodule
